// File: rtl/sxpe_pkg.sv
`default_nettype none

package sxpe_pkg;

    localparam int CELL_BITS  = 128;
    localparam int HALF_BITS  = 64;
    localparam int CHUNK_W    = 4;
    localparam int CELL_IDX_W = 11;
    localparam int SHIFT_W    = 7;
    localparam int ENABLE_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic ACT_ACCUM = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DATA_CHUNKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_CHUNKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_COUNT    = 2'd3;

    localparam logic [4:0]  RST_DATA_CHUNKS   = 5'd4;
    localparam logic [2:0]  RST_PARITY_CHUNKS = 3'd2;
    localparam logic [3:0]  RST_PARITY_ENABLE = 4'd15;
    localparam logic [10:0] RST_CELL_COUNT    = 11'd1024;

    typedef struct packed {
        logic                  action;
        logic [CHUNK_W-1:0]    chunk_index;
        logic [CELL_IDX_W-1:0] cell_index;
        logic [HALF_BITS-1:0]  cell_lo;
        logic [HALF_BITS-1:0]  cell_hi;
    } req_t;

    typedef struct packed {
        logic [HALF_BITS-1:0] parity_lo;
        logic [HALF_BITS-1:0] parity_hi;
        logic                 out_of_range;
    } rsp_t;

    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [SHIFT_W-1:0] row_max;
    } shift_info_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_WRITE
    } state_t;

endpackage

`default_nettype wire

// File: rtl/shifted_xor_parity_encoder.sv
`default_nettype none

// Channel    Handshake              Payload                       Direction
// ---------  ---------------------  ----------------------------  ---------
// item       start / busy           request (req_t)               in
// result     done (one-cycle beat)  result (rsp_t)                out
// config     cfg_valid / cfg_ready  cfg_index, cfg_data           in
//
// Each item passes accept, parity bank read, then write-back with the result
// beat for a read item; the registered read of the banks separates the last two steps.
// After reset a clearing pass zeroes all MAX_CELLS + SHIFT_CAP rows of every
// bank, one row address per cycle across every bank; busy stays high meanwhile.
// Configuration writes are taken in every cycle.
// The receiver cannot stall: a result is shown for exactly one cycle.

module shifted_xor_parity_encoder #(
    parameter int MAX_DATA_CHUNKS   = 16,
    parameter int MAX_PARITY_CHUNKS = 4,
    parameter int MAX_CELLS         = 1024,
    parameter int SHIFT_CAP         = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire sxpe_pkg::req_t                      request,
    output logic                                     done,
    output sxpe_pkg::rsp_t                           result,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sxpe_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sxpe_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ROW_CELLS = MAX_CELLS + SHIFT_CAP;
    localparam int ROW_W     = (ROW_CELLS > 1) ? $clog2(ROW_CELLS) : 1;
    localparam int LEN_W     = $clog2(ROW_CELLS + 1);
    localparam int WIDE_W    = (LEN_W > sxpe_pkg::CELL_IDX_W) ? LEN_W : sxpe_pkg::CELL_IDX_W;
    localparam int BANKS     = MAX_PARITY_CHUNKS;

    // Configuration registers.
    logic [4:0]  data_chunks_reg;
    logic [2:0]  parity_chunks_reg;
    logic [3:0]  parity_enable_reg;
    logic [10:0] cell_count_reg;

    sxpe_pkg::state_t state_reg, state_next;
    logic [ROW_W-1:0] clear_cnt_reg, clear_cnt_next;
    logic             clear_last;

    sxpe_pkg::req_t req_reg;

    // Effective sizes.
    logic [5:0]        k_wide;
    logic [4:0]        k_eff;
    logic [3:0]        m_pre;
    logic [2:0]        m_eff;
    logic [WIDE_W-1:0] cells_eff;

    sxpe_pkg::shift_info_t info [BANKS];
    logic [BANKS-1:0]      bank_en;
    logic [BANKS-1:0]      acc_hit;
    logic [BANKS-1:0]      rd_en;
    logic [ROW_W-1:0]      addr [BANKS];
    logic                  acc_ok;
    logic                  rd_ok;
    logic [sxpe_pkg::SHIFT_W-1:0] row_max_sel;
    logic [WIDE_W-1:0]     row_len;
    logic [WIDE_W-1:0]     row_extra;

    logic [BANKS-1:0]              wr_en_reg;
    logic [ROW_W-1:0]              addr_reg [BANKS];
    logic                          op_read_reg;
    logic                          rd_ok_reg;
    logic [sxpe_pkg::CELL_BITS-1:0] rdata_reg [BANKS];
    logic [BANKS-1:0]              mem_we;
    logic [sxpe_pkg::CELL_BITS-1:0] rd_sel;
    logic                          in_access;
    logic                          in_write;
    logic                          in_clear;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_chunks_reg   <= sxpe_pkg::RST_DATA_CHUNKS;
            parity_chunks_reg <= sxpe_pkg::RST_PARITY_CHUNKS;
            parity_enable_reg <= sxpe_pkg::RST_PARITY_ENABLE;
            cell_count_reg    <= sxpe_pkg::RST_CELL_COUNT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sxpe_pkg::CFG_DATA_CHUNKS:   data_chunks_reg   <= cfg_data[4:0];
                sxpe_pkg::CFG_PARITY_CHUNKS: parity_chunks_reg <= cfg_data[2:0];
                sxpe_pkg::CFG_PARITY_ENABLE: parity_enable_reg <= cfg_data[3:0];
                sxpe_pkg::CFG_CELL_COUNT:    cell_count_reg    <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        k_wide    = (6'(data_chunks_reg) < 6'(MAX_DATA_CHUNKS)) ?
                    6'(data_chunks_reg) : 6'(MAX_DATA_CHUNKS);
        k_eff     = k_wide[4:0];
        m_pre     = (4'(parity_chunks_reg) < 4'(MAX_PARITY_CHUNKS)) ?
                    4'(parity_chunks_reg) : 4'(MAX_PARITY_CHUNKS);
        m_eff     = (5'(m_pre) < k_eff) ? m_pre[2:0] : k_eff[2:0];
        cells_eff = (WIDE_W'(cell_count_reg) < WIDE_W'(MAX_CELLS)) ?
                    WIDE_W'(cell_count_reg) : WIDE_W'(MAX_CELLS);
    end

    // FSM.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sxpe_pkg::ST_CLEAR;
            clear_cnt_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_cnt_reg <= clear_cnt_next;
        end
    end

    assign clear_last = (clear_cnt_reg == ROW_W'(ROW_CELLS - 1));

    always_comb
    begin
        state_next     = state_reg;
        clear_cnt_next = clear_cnt_reg;
        busy           = 1'b1;
        done           = 1'b0;
        in_access      = 1'b0;
        in_write       = 1'b0;
        in_clear       = 1'b0;
        unique case (state_reg)
            sxpe_pkg::ST_CLEAR:
            begin
                in_clear       = 1'b1;
                clear_cnt_next = clear_cnt_reg + ROW_W'(1);
                if (clear_last)
                begin
                    state_next = sxpe_pkg::ST_IDLE;
                end
            end
            sxpe_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    state_next = sxpe_pkg::ST_ACCESS;
                end
            end
            sxpe_pkg::ST_ACCESS:
            begin
                in_access  = 1'b1;
                state_next = sxpe_pkg::ST_WRITE;
            end
            sxpe_pkg::ST_WRITE:
            begin
                in_write   = 1'b1;
                done       = op_read_reg;
                state_next = sxpe_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = sxpe_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
    end

    // Shift and address per parity bank.
    for (genvar b = 0; b < BANKS; b++)
    begin : g_shift
        sxpe_shift u_shift (
            .k    (k_eff),
            .m    (m_eff),
            .p    (3'(b)),
            .d    (req_reg.chunk_index),
            .info (info[b])
        );

        if (b < sxpe_pkg::ENABLE_W)
        begin : g_en
            assign bank_en[b] = parity_enable_reg[b];
        end
        else
        begin : g_off
            assign bank_en[b] = 1'b0;
        end
    end

    always_comb
    begin
        acc_ok = (req_reg.action == sxpe_pkg::ACT_ACCUM) &&
                 (5'(req_reg.chunk_index) < k_eff) &&
                 (WIDE_W'(req_reg.cell_index) < cells_eff);
        row_max_sel = '0;
        for (int b = 0; b < BANKS; b++)
        begin
            if (req_reg.chunk_index == 4'(b))
            begin
                row_max_sel = info[b].row_max;
            end
        end
        row_extra = (WIDE_W'(row_max_sel) > WIDE_W'(SHIFT_CAP)) ?
                    WIDE_W'(SHIFT_CAP) : WIDE_W'(row_max_sel);
        row_len   = cells_eff + row_extra;
        rd_ok     = (req_reg.action == sxpe_pkg::ACT_READ) &&
                    (4'(m_eff) > req_reg.chunk_index) &&
                    (WIDE_W'(req_reg.cell_index) < row_len);
        for (int b = 0; b < BANKS; b++)
        begin
            acc_hit[b] = acc_ok && (3'(b) < m_eff) && bank_en[b] &&
                         (WIDE_W'(info[b].shift) <= WIDE_W'(SHIFT_CAP));
            rd_en[b]   = acc_hit[b] || (rd_ok && (req_reg.chunk_index == 4'(b)));
            if (req_reg.action == sxpe_pkg::ACT_READ)
            begin
                addr[b] = ROW_W'(req_reg.cell_index);
            end
            else
            begin
                addr[b] = ROW_W'(WIDE_W'(req_reg.cell_index) + WIDE_W'(info[b].shift));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_en_reg <= '0;
        end
        else if (in_access)
        begin
            wr_en_reg <= rd_en;
        end
        else if (in_write)
        begin
            wr_en_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_access)
        begin
            op_read_reg <= (req_reg.action == sxpe_pkg::ACT_READ);
            rd_ok_reg   <= rd_ok;
            for (int b = 0; b < BANKS; b++)
            begin
                addr_reg[b] <= addr[b];
            end
        end
    end

    // One bank per parity chunk. Items run one at a time, so a write-back
    // never overlaps a read of the same entry.
    for (genvar b = 0; b < BANKS; b++)
    begin : g_bank
        logic [sxpe_pkg::CELL_BITS-1:0] mem [ROW_CELLS];
        logic [ROW_W-1:0]               wa;
        logic [sxpe_pkg::CELL_BITS-1:0] wd;

        assign mem_we[b] = in_clear || (in_write && wr_en_reg[b]);
        assign wa        = in_clear ? clear_cnt_reg : addr_reg[b];
        assign wd        = (in_clear || op_read_reg) ? '0 :
                           (rdata_reg[b] ^ {req_reg.cell_hi, req_reg.cell_lo});

        always_ff @(posedge clk)
        begin
            if (mem_we[b])
            begin
                mem[wa] <= wd;
            end
        end

        always_ff @(posedge clk)
        begin
            if (in_access && rd_en[b])
            begin
                rdata_reg[b] <= mem[addr[b]];
            end
        end
    end

    always_comb
    begin
        rd_sel = '0;
        for (int b = 0; b < BANKS; b++)
        begin
            if (req_reg.chunk_index == 4'(b))
            begin
                rd_sel = rdata_reg[b];
            end
        end
        if (rd_ok_reg)
        begin
            result.parity_lo    = rd_sel[sxpe_pkg::HALF_BITS-1:0];
            result.parity_hi    = rd_sel[sxpe_pkg::CELL_BITS-1:sxpe_pkg::HALF_BITS];
            result.out_of_range = 1'b0;
        end
        else
        begin
            result.parity_lo    = '0;
            result.parity_hi    = '0;
            result.out_of_range = 1'b1;
        end
    end

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.out_of_range |-> result.parity_lo == '0 && result.parity_hi == '0)
        else $error("rejected read carries nonzero data");

    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sxpe_pkg::ST_IDLE || state_reg == sxpe_pkg::ST_ACCESS)
        |-> mem_we == '0)
        else $error("parity bank written outside write-back or clear");

    a_read_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
        in_write && op_read_reg |-> $onehot0(wr_en_reg))
        else $error("read clears more than one bank");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.action == sxpe_pkg::ACT_READ |-> ##2 done)
        else $error("read item produced no result beat");

    a_accum_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && request.action == sxpe_pkg::ACT_ACCUM |-> ##2 !done)
        else $error("accumulate item produced a result beat");

endmodule

`default_nettype wire

// File: rtl/sxpe_shift.sv
`default_nettype none

module sxpe_shift (
    input  wire logic [4:0]                   k,
    input  wire logic [2:0]                   m,
    input  wire logic [2:0]                   p,
    input  wire logic [sxpe_pkg::CHUNK_W-1:0] d,
    output sxpe_pkg::shift_info_t             info
);

    logic [3:0] m_plus;
    logic [2:0] half;
    logic [2:0] q;
    logic [2:0] factor;
    logic [4:0] mult;
    logic [4:0] k_less;
    logic [7:0] shift_full;
    logic [7:0] row_full;

    // The rule is only meaningful for p < m and d < k; the caller gates the rest.
    always_comb
    begin
        m_plus = 4'(m) + 4'd1;
        half   = m_plus[3:1];
        q      = m - 3'd1 - p;
        k_less = k - 5'd1;
        if (q < half)
        begin
            factor = half - 3'd1 - q;
            mult   = k_less - 5'(d);
        end
        else
        begin
            factor = q - half + 3'd1;
            mult   = 5'(d);
        end
        // Largest shift of the row: d = 0 for the descending side, d = k-1 otherwise.
        shift_full   = 8'(factor) * 8'(mult);
        row_full     = 8'(factor) * 8'(k_less);
        info.shift   = shift_full[sxpe_pkg::SHIFT_W-1:0];
        info.row_max = row_full[sxpe_pkg::SHIFT_W-1:0];
    end

endmodule

`default_nettype wire

// File: bench/sxpe_parity_monitor.sv
module sxpe_parity_monitor #(
    parameter int MAX_DATA_CHUNKS   = 16,
    parameter int MAX_PARITY_CHUNKS = 4,
    parameter int MAX_CELLS         = 1024,
    parameter int SHIFT_CAP         = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  sxpe_pkg::req_t                    request,
    input  logic                              done,
    input  sxpe_pkg::rsp_t                    result,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [sxpe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sxpe_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatches,
    output int                                outstanding
);
    import sxpe_pkg::*;

    localparam int ROW_CELLS = MAX_CELLS + SHIFT_CAP;

    logic [4:0]          data_chunks;
    logic [2:0]          parity_chunks;
    logic [ENABLE_W-1:0] parity_enable;
    logic [10:0]         cell_count;

    // Each parity row is ROW_CELLS long; row p starts at p * ROW_CELLS.
    bit [CELL_BITS-1:0] parity_rows [MAX_PARITY_CHUNKS*ROW_CELLS];
    rsp_t               expected_reads [$];
    int                 error_total;

    function automatic int unsigned shift_amount(int unsigned p, int unsigned d,
                                                 int unsigned k, int unsigned m);
        int unsigned half;
        int unsigned q;
        // Integer division makes (m + 1) / 2 equal to m / 2 when m is even.
        half = (m + 1) / 2;
        q = m - 1 - p;
        if (q < half)
            return (half - 1 - q) * (k - 1 - d);
        return (q - half + 1) * d;
    endfunction

    function automatic int unsigned row_length(int unsigned p, int unsigned k,
                                               int unsigned m, int unsigned cells);
        int unsigned widest;
        int unsigned d;
        widest = 0;
        for (d = 0; d < k; d++)
        begin
            if (shift_amount(p, d, k, m) > widest)
                widest = shift_amount(p, d, k, m);
        end
        if (widest > SHIFT_CAP)
            widest = SHIFT_CAP;
        return cells + widest;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t        seen;
        rsp_t        want;
        req_t        item;
        int unsigned k;
        int unsigned m;
        int unsigned cells;
        int unsigned p;
        int unsigned s;
        int unsigned pos;
        if (!rst_n)
        begin
            data_chunks   = RST_DATA_CHUNKS;
            parity_chunks = RST_PARITY_CHUNKS;
            parity_enable = RST_PARITY_ENABLE;
            cell_count    = RST_CELL_COUNT;
            expected_reads.delete();
            error_total = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                seen = result;
                if (expected_reads.size() == 0)
                begin
                    $error("result beat with no read outstanding: lo %h hi %h flag %b",
                           seen.parity_lo, seen.parity_hi, seen.out_of_range);
                    error_total++;
                end
                else
                begin
                    want = expected_reads.pop_front();
                    if (seen.parity_lo !== want.parity_lo)
                    begin
                        $error("parity_lo: expected %h, got %h", want.parity_lo,
                               seen.parity_lo);
                        error_total++;
                    end
                    if (seen.parity_hi !== want.parity_hi)
                    begin
                        $error("parity_hi: expected %h, got %h", want.parity_hi,
                               seen.parity_hi);
                        error_total++;
                    end
                    if (seen.out_of_range !== want.out_of_range)
                    begin
                        $error("out_of_range: expected %b, got %b", want.out_of_range,
                               seen.out_of_range);
                        error_total++;
                    end
                end
            end

            if (start && !busy)
            begin
                item  = request;
                k     = (data_chunks < MAX_DATA_CHUNKS) ? data_chunks : MAX_DATA_CHUNKS;
                m     = (parity_chunks < MAX_PARITY_CHUNKS) ? parity_chunks
                                                            : MAX_PARITY_CHUNKS;
                if (m > k)
                    m = k;
                cells = (cell_count < MAX_CELLS) ? cell_count : MAX_CELLS;
                if (item.action == ACT_ACCUM)
                begin
                    if (item.chunk_index < k && item.cell_index < cells)
                    begin
                        for (p = 0; p < m; p++)
                        begin
                            s   = shift_amount(p, item.chunk_index, k, m);
                            pos = item.cell_index + s;
                            if (parity_enable[p] && s <= SHIFT_CAP && pos < ROW_CELLS)
                                parity_rows[p*ROW_CELLS+pos] ^= {item.cell_hi, item.cell_lo};
                        end
                    end
                end
                else
                begin
                    if (item.chunk_index >= m || item.cell_index >= ROW_CELLS
                        || item.cell_index >= row_length(item.chunk_index, k, m, cells))
                    begin
                        want.parity_lo    = '0;
                        want.parity_hi    = '0;
                        want.out_of_range = 1'b1;
                    end
                    else
                    begin
                        pos = item.chunk_index * ROW_CELLS + item.cell_index;
                        want.parity_lo    = parity_rows[pos][HALF_BITS-1:0];
                        want.parity_hi    = parity_rows[pos][CELL_BITS-1:HALF_BITS];
                        want.out_of_range = 1'b0;
                        parity_rows[pos]  = '0;
                    end
                    expected_reads.insert(expected_reads.size(), want);
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_DATA_CHUNKS:   data_chunks   = cfg_data[4:0];
                    CFG_PARITY_CHUNKS: parity_chunks = cfg_data[2:0];
                    CFG_PARITY_ENABLE: parity_enable = cfg_data[ENABLE_W-1:0];
                    CFG_CELL_COUNT:    cell_count    = cfg_data[10:0];
                    default: ;
                endcase
            end

            mismatches  <= error_total;
            outstanding <= expected_reads.size();
        end
    end

endmodule

// File: bench/tb.sv
module tb;
    import sxpe_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int ITEM_TARGET   = 850;
    localparam int PHASE_ITEMS   = 60;
    localparam int SETTLE_CYCLES = 4;
    localparam int DATA_CAP      = 16;
    localparam int PARITY_CAP    = 4;
    localparam int CELL_CAP      = 1024;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    req_t                  request   = '0;
    logic                  done;
    rsp_t                  result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int outstanding;
    int stall_cycles = 0;
    int idle_pct     = 33;
    int items_sent   = 0;
    int phase_items  = 0;
    int cur_k        = 4;
    int cur_m        = 2;
    int cur_cells    = 1024;

    shifted_xor_parity_encoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sxpe_parity_monitor u_monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Any beat on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic [HALF_BITS-1:0] random_half();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Holds start until the beat is taken; the sender idle rate follows progress.
    task automatic push_item(input req_t r, input bit counted);
        idle_pct = (items_sent < ITEM_TARGET / 3) ? 33 :
                   (items_sent < 2 * ITEM_TARGET / 3) ? 88 : 0;
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        phase_items++;
        if (counted)
            items_sent++;
    endtask

    task automatic issue(input logic act, input logic [CHUNK_W-1:0] chunk,
                         input logic [CELL_IDX_W-1:0] cell_pos,
                         input logic [HALF_BITS-1:0] lo, input logic [HALF_BITS-1:0] hi);
        req_t r;
        r.action      = act;
        r.chunk_index = chunk;
        r.cell_index  = cell_pos;
        r.cell_lo     = lo;
        r.cell_hi     = hi;
        push_item(r, 1'b1);
    endtask

    task automatic send_noise();
        req_t r;
        r.action      = 1'($urandom_range(1));
        r.chunk_index = CHUNK_W'($urandom_range(15));
        r.cell_index  = CELL_IDX_W'($urandom_range(2047));
        r.cell_lo     = random_half();
        r.cell_hi     = random_half();
        push_item(r, r.action == ACT_READ);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(11) == 0)
            send_noise();
    endtask

    // Waits until every read has returned and the block is idle, then lets the
    // pipeline run out before anything else happens.
    task automatic wait_quiet();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0 || busy);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_settings(input int k, input int m, input int en, input int cells);
        int                    values [4];
        int                    widths [4];
        logic [CFG_IDX_W-1:0]  regs [4];
        logic [CFG_DATA_W-1:0] word;
        logic [CFG_DATA_W-1:0] junk;
        values = '{k, m, en, cells};
        widths = '{5, 3, 4, 11};
        regs   = '{CFG_DATA_CHUNKS, CFG_PARITY_CHUNKS, CFG_PARITY_ENABLE, CFG_CELL_COUNT};
        wait_quiet();
        for (int i = 0; i < 4; i++)
        begin
            word = CFG_DATA_W'(values[i] & ((1 << widths[i]) - 1));
            // Bits above the register width must be dropped by the block.
            if ($urandom_range(3) == 0)
            begin
                junk = CFG_DATA_W'($urandom);
                word = word | (junk << widths[i]);
            end
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data  <= word;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        cur_k     = (k < DATA_CAP) ? k : DATA_CAP;
        cur_m     = (m < PARITY_CAP) ? m : PARITY_CAP;
        if (cur_m > cur_k)
            cur_m = cur_k;
        cur_cells = (cells < CELL_CAP) ? cells : CELL_CAP;
    endtask

    // One full encode over a small window of cells: every data chunk is
    // accumulated, then every parity cell the window can touch is read back.
    task automatic run_encode();
        int span;
        int base;
        int extra;
        int rows;
        span = 0;
        base = 0;
        if (cur_cells > 0)
        begin
            span = $urandom_range((cur_k > 8) ? 2 : 4, 1);
            if (span > cur_cells)
                span = cur_cells;
            if ($urandom_range(3) == 0)
                base = cur_cells - span;
            else
                base = $urandom_range(cur_cells - span, 0);
        end
        for (int d = 0; d < cur_k; d++)
        begin
            for (int c = base; c < base + span; c++)
            begin
                maybe_noise();
                issue(ACT_ACCUM, CHUNK_W'(d), CELL_IDX_W'(c), random_half(), random_half());
            end
        end
        // Shifts never exceed twice the data count, so this covers each row's
        // tail and usually steps past its end.
        extra = 2 * cur_k;
        rows  = cur_m + (($urandom_range(3) == 0) ? 1 : 0);
        for (int p = 0; p < rows; p++)
        begin
            for (int t = base; t < base + span + extra; t++)
            begin
                maybe_noise();
                issue(ACT_READ, CHUNK_W'(p), CELL_IDX_W'(t), random_half(), random_half());
            end
        end
        if (cur_m > 0 && $urandom_range(2) == 0)
            issue(ACT_READ, 0, CELL_IDX_W'(base), random_half(), random_half());
    endtask

    initial
    begin
        int k_tab     [9];
        int m_tab     [9];
        int en_tab    [9];
        int cells_tab [9];
        int budget;
        int ph;

        k_tab     = '{4, 16, 2, 5, 16, 3, 31, 0, 4};
        m_tab     = '{2, 4, 1, 3, 4, 7, 7, 2, 3};
        en_tab    = '{15, 15, 1, 5, 0, 10, 15, 15, 6};
        cells_tab = '{1024, 4, 1, 8, 3, 2, 2047, 5, 0};

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: four data chunks, two parity rows, shift of row 0
        // equals the data chunk, row 1 is unshifted.
        issue(ACT_ACCUM, 0, 0, '1, '1);
        issue(ACT_ACCUM, 3, 1023, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
        issue(ACT_ACCUM, 4, 5, random_half(), random_half());
        issue(ACT_ACCUM, 15, 2047, '1, '1);
        issue(ACT_ACCUM, 1, 1024, random_half(), random_half());
        issue(ACT_ACCUM, 2, 5, random_half(), random_half());
        issue(ACT_ACCUM, 1, 4, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        issue(ACT_READ, 0, 0, '0, '0);
        issue(ACT_READ, 0, 0, '1, '1);
        issue(ACT_READ, 1, 0, random_half(), random_half());
        issue(ACT_READ, 0, 1026, random_half(), random_half());
        issue(ACT_READ, 0, 1027, random_half(), random_half());
        issue(ACT_READ, 1, 1023, random_half(), random_half());
        issue(ACT_READ, 1, 1024, random_half(), random_half());
        issue(ACT_READ, 0, 7, random_half(), random_half());
        issue(ACT_READ, 0, 5, random_half(), random_half());
        issue(ACT_READ, 1, 5, random_half(), random_half());
        issue(ACT_READ, 1, 4, random_half(), random_half());
        issue(ACT_READ, 2, 0, random_half(), random_half());
        issue(ACT_READ, 15, 2047, '1, '1);
        issue(ACT_READ, 0, 2047, random_half(), random_half());

        ph = 0;
        while (items_sent < ITEM_TARGET)
        begin
            if (ph < 9)
                load_settings(k_tab[ph], m_tab[ph], en_tab[ph], cells_tab[ph]);
            else
                load_settings($urandom_range(16, 2), $urandom_range(4, 1),
                              $urandom_range(15, 0),
                              ($urandom_range(4) == 0) ? 1024 : $urandom_range(16, 1));
            ph++;
            phase_items = 0;
            budget = (cur_k == 0 || cur_cells == 0) ? 20 : PHASE_ITEMS;
            while (phase_items < budget)
            begin
                if (cur_m == 0 || $urandom_range(7) == 0)
                    send_noise();
                else
                begin
                    run_encode();
                    if ($urandom_range(3) == 0)
                        wait_quiet();
                end
            end
        end

        wait_quiet();
        if (mismatches == 0 && outstanding == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
